// ----- rtl/sihm_pkg.sv -----
// ----------------------------------------------------------------------------
// sihm_pkg
// Shared types and codes for the stream id to handle map.
// ----------------------------------------------------------------------------
package sihm_pkg;

    localparam int KeyWidth    = 32;
    localparam int HandleWidth = 16;
    localparam int OpWidth     = 3;
    localparam int StatusWidth = 2;
    localparam int CountWidth  = 8;

    // Operation codes.
    localparam logic [OpWidth-1:0] OP_ADD        = 3'd0;
    localparam logic [OpWidth-1:0] OP_FIND_SID   = 3'd1;
    localparam logic [OpWidth-1:0] OP_FIND_HND   = 3'd2;
    localparam logic [OpWidth-1:0] OP_REMOVE_SID = 3'd3;
    localparam logic [OpWidth-1:0] OP_REMOVE_HND = 3'd4;
    localparam logic [OpWidth-1:0] OP_CLEAR      = 3'd5;

    // Status codes.
    localparam logic [StatusWidth-1:0] ST_OK        = 2'd0;
    localparam logic [StatusWidth-1:0] ST_FULL      = 2'd1;
    localparam logic [StatusWidth-1:0] ST_NOT_FOUND = 2'd2;

    typedef logic [OpWidth-1:0]     t_opcode;
    typedef logic [StatusWidth-1:0] t_status;
    typedef logic [KeyWidth-1:0]    t_key;
    typedef logic [HandleWidth-1:0] t_handle;
    typedef logic [CountWidth-1:0]  t_count_out;

    // One table entry as held in the memory.
    typedef struct packed {
        t_key    key;
        t_handle handle;
    } t_entry;

endpackage

// ----- rtl/stream_id_handle_map.sv -----
// ----------------------------------------------------------------------------
// stream_id_handle_map
// Packed table of (stream id, handle) pairs in one synchronous memory,
// searched by a linear scan with swap-from-last removal.
// ----------------------------------------------------------------------------
// Add, clear and unused opcodes give their result in the cycle after the
// transfer, as does a find or remove on an empty table. Otherwise a find
// or remove scans from slot 0 through the single-read-port memory, one
// entry per cycle, until a hit or the last entry; a remove that moves the
// last entry passes a write-back state. Busy is high until the strobe.
// Reset (synchronous, active low) empties the table; the memory needs no
// clearing pass. Results are strobed for one cycle and cannot be stalled.
module stream_id_handle_map #(
    parameter int DEPTH = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  sihm_pkg::t_opcode     i_opcode,
    input  sihm_pkg::t_key        i_stream_id,
    input  sihm_pkg::t_handle     i_local_handle,
    output logic                  o_valid,
    output sihm_pkg::t_status     o_status,
    output sihm_pkg::t_handle     o_found_handle,
    output sihm_pkg::t_key        o_found_stream_id,
    output sihm_pkg::t_count_out  o_entry_count
);
    import sihm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // slot index width
    localparam int CW = $clog2(DEPTH + 1);                 // count width

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_WB   = 2'd2;

    localparam logic [CW-1:0] FullCount = CW'(DEPTH);

    // Table storage: one write port, one registered read port.
    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Control state.
    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rd_idx, n_rd_idx;     // next slot to read
    logic [CW-1:0] r_cmp_idx, n_cmp_idx;   // slot whose data sits in r_rdata
    logic          r_rd_vld, n_rd_vld;     // r_rdata holds a scanned slot
    logic [CW-1:0] r_slot, n_slot;         // slot being refilled on remove

    // Latched operation.
    t_opcode r_op;
    t_key    r_sid;
    t_handle r_hnd;

    // Result registers.
    logic       r_valid, n_valid;
    t_status    r_status, n_status;
    t_handle    r_fh, n_fh;
    t_key       r_fs, n_fs;
    t_count_out r_cnt_out, n_cnt_out;

    // Memory access controls.
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;

    logic          accept;
    logic          by_stream;
    logic          is_find;
    logic          hit;
    logic [CW-1:0] last_idx;
    logic          last_cmp;
    logic [CW+CountWidth-1:0] cnt_wide;

    assign accept    = start && !busy;
    assign by_stream = (r_op == OP_FIND_SID) || (r_op == OP_REMOVE_SID);
    assign is_find   = (r_op == OP_FIND_SID) || (r_op == OP_FIND_HND);
    assign last_idx  = r_count - CW'(1);
    assign hit       = r_rd_vld && (by_stream ? (r_rdata.key == r_sid)
                                              : (r_rdata.handle == r_hnd));
    assign last_cmp  = r_rd_vld && (r_cmp_idx == last_idx);

    // The reported count is the low bits of the count after the operation.
    assign cnt_wide  = {{CountWidth{1'b0}}, n_count};
    assign n_cnt_out = cnt_wide[CountWidth-1:0];

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_rd_idx  = r_rd_idx;
        n_cmp_idx = r_cmp_idx;
        n_rd_vld  = 1'b0;
        n_slot    = r_slot;
        n_valid   = 1'b0;
        n_status  = ST_OK;
        n_fh      = '0;
        n_fs      = '0;
        rd_en     = 1'b0;
        rd_addr   = r_rd_idx[AW-1:0];
        wr_en     = 1'b0;
        wr_addr   = r_count[AW-1:0];
        wr_data   = '{key: i_stream_id, handle: i_local_handle};

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    priority if (i_opcode == OP_ADD) begin
                        n_valid = 1'b1;
                        if (r_count >= FullCount) begin
                            n_status = ST_FULL;
                        end else begin
                            wr_en   = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end else if (i_opcode == OP_CLEAR) begin
                        n_valid = 1'b1;
                        n_count = '0;
                    end else if ((i_opcode == OP_FIND_SID) || (i_opcode == OP_FIND_HND) ||
                                 (i_opcode == OP_REMOVE_SID) ||
                                 (i_opcode == OP_REMOVE_HND)) begin
                        if (r_count == '0) begin
                            n_valid  = 1'b1;
                            n_status = ST_NOT_FOUND;
                        end else begin
                            // Start the scan: read slot 0 now.
                            rd_en     = 1'b1;
                            rd_addr   = '0;
                            n_rd_vld  = 1'b1;
                            n_cmp_idx = '0;
                            n_rd_idx  = CW'(1);
                            n_state   = S_SCAN;
                        end
                    end else begin
                        n_valid = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                priority if (hit) begin
                    if (is_find) begin
                        n_valid = 1'b1;
                        if (r_op == OP_FIND_SID) begin
                            n_fh = r_rdata.handle;
                        end else begin
                            n_fs = r_rdata.key;
                        end
                        n_state = S_IDLE;
                    end else if (r_cmp_idx == last_idx) begin
                        // Removing the last slot just shrinks the table.
                        n_valid = 1'b1;
                        n_count = last_idx;
                        n_state = S_IDLE;
                    end else begin
                        // Fetch the last entry to move it into the freed slot.
                        rd_en   = 1'b1;
                        rd_addr = last_idx[AW-1:0];
                        n_slot  = r_cmp_idx;
                        n_state = S_WB;
                    end
                end else if (last_cmp) begin
                    n_valid  = 1'b1;
                    n_status = ST_NOT_FOUND;
                    n_state  = S_IDLE;
                end else begin
                    // Keep one read in flight ahead of the compare.
                    rd_en     = (r_rd_idx < r_count);
                    n_rd_vld  = rd_en;
                    n_cmp_idx = r_rd_idx;
                    n_rd_idx  = r_rd_idx + CW'(1);
                end
            end
            S_WB: begin
                wr_en   = 1'b1;
                wr_addr = r_slot[AW-1:0];
                wr_data = r_rdata;
                n_valid = 1'b1;
                n_count = last_idx;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memory ports.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_vld <= n_rd_vld;
            r_valid  <= n_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rd_idx  <= n_rd_idx;
        r_cmp_idx <= n_cmp_idx;
        r_slot    <= n_slot;
        r_status  <= n_status;
        r_fh      <= n_fh;
        r_fs      <= n_fs;
        r_cnt_out <= n_cnt_out;
        if (accept) begin
            r_op  <= i_opcode;
            r_sid <= i_stream_id;
            r_hnd <= i_local_handle;
        end
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_status          = r_status;
    assign o_found_handle    = r_fh;
    assign o_found_stream_id = r_fs;
    assign o_entry_count     = r_cnt_out;

    // The table never holds more entries than it has slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FullCount)
        else $error("entry count exceeds table depth");

    // A compared slot always lies inside the valid part of the table.
    a_cmp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_rd_vld) |-> (r_cmp_idx < r_count))
        else $error("scan compared a slot beyond the entry count");

    // A result follows either a transfer or a cycle of ongoing work.
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(start && !busy) || $past(busy)))
        else $error("result strobe without a pending operation");

    // Removal write-back only happens for a remove opcode.
    a_wb_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB) |-> ((r_op == OP_REMOVE_SID) || (r_op == OP_REMOVE_HND)))
        else $error("write-back state entered by a non-remove operation");

endmodule

// ----- tb/sv/tb_stream_id_handle_map.sv -----
// ----------------------------------------------------------------------------
// tb_stream_id_handle_map
// Self-checking bench for the stream id to handle map. A scoreboard keeps
// its own copy of the packed table, predicts one answer per command and
// compares every strobed result against it. Stimulus is a directed opening
// followed by random episodes with different add/remove mixes, so that the
// table fills up, overflows and drains repeatedly.
// ----------------------------------------------------------------------------

typedef struct {
    sihm_pkg::t_status    status;
    sihm_pkg::t_handle    handle;
    sihm_pkg::t_key       found_sid;
    sihm_pkg::t_count_out count;
} t_map_answer;

class map_scoreboard #(int DEPTH = 128);

    sihm_pkg::t_key    key_tab [DEPTH];
    sihm_pkg::t_handle hnd_tab [DEPTH];
    int unsigned       fill;
    t_map_answer       answer_q [$];
    int unsigned       errors;

    function new();
        fill   = 0;
        errors = 0;
    endfunction

    // First slot in table order holding the stream id, or -1.
    function int key_slot(sihm_pkg::t_key key);
        for (int i = 0; i < fill; i++) begin
            if (key_tab[i] == key) return i;
        end
        return -1;
    endfunction

    // First slot in table order holding the handle, or -1.
    function int handle_slot(sihm_pkg::t_handle hnd);
        for (int i = 0; i < fill; i++) begin
            if (hnd_tab[i] == hnd) return i;
        end
        return -1;
    endfunction

    // The last valid pair moves into the freed slot.
    function void drop_slot(int slot);
        key_tab[slot] = key_tab[fill-1];
        hnd_tab[slot] = hnd_tab[fill-1];
        fill--;
    endfunction

    // Updates the table for one accepted command and queues its answer.
    function void apply_command(sihm_pkg::t_opcode op, sihm_pkg::t_key sid,
                                sihm_pkg::t_handle hnd);
        t_map_answer ans;
        int          slot;
        ans.status    = sihm_pkg::ST_OK;
        ans.handle    = '0;
        ans.found_sid = '0;
        case (op)
            sihm_pkg::OP_ADD: begin
                if (fill >= DEPTH) begin
                    ans.status = sihm_pkg::ST_FULL;
                end else begin
                    key_tab[fill] = sid;
                    hnd_tab[fill] = hnd;
                    fill++;
                end
            end
            sihm_pkg::OP_FIND_SID: begin
                slot = key_slot(sid);
                if (slot >= 0) ans.handle = hnd_tab[slot];
                else ans.status = sihm_pkg::ST_NOT_FOUND;
            end
            sihm_pkg::OP_FIND_HND: begin
                slot = handle_slot(hnd);
                if (slot >= 0) ans.found_sid = key_tab[slot];
                else ans.status = sihm_pkg::ST_NOT_FOUND;
            end
            sihm_pkg::OP_REMOVE_SID: begin
                slot = key_slot(sid);
                if (slot >= 0) drop_slot(slot);
                else ans.status = sihm_pkg::ST_NOT_FOUND;
            end
            sihm_pkg::OP_REMOVE_HND: begin
                slot = handle_slot(hnd);
                if (slot >= 0) drop_slot(slot);
                else ans.status = sihm_pkg::ST_NOT_FOUND;
            end
            sihm_pkg::OP_CLEAR: begin
                fill = 0;
            end
            default: begin
            end
        endcase
        ans.count = sihm_pkg::t_count_out'(fill);
        answer_q.push_back(ans);
    endfunction

    function void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            errors++;
        end
    endfunction

    // Compares one strobed result against the oldest outstanding answer.
    function void check_answer(sihm_pkg::t_status status, sihm_pkg::t_handle hnd,
                               sihm_pkg::t_key sid, sihm_pkg::t_count_out count);
        t_map_answer ans;
        if (answer_q.size() == 0) begin
            $display("%0t: result with no outstanding command, status %0h count %0h",
                     $time, status, count);
            errors++;
        end else begin
            ans = answer_q.pop_front();
            check_field("status", ans.status, status);
            check_field("found_handle", ans.handle, hnd);
            check_field("found_stream_id", ans.found_sid, sid);
            check_field("entry_count", ans.count, count);
        end
    endfunction

endclass

module tb_stream_id_handle_map;
    import sihm_pkg::*;

    localparam int MAP_DEPTH = 128;
    // Random commands issued after the directed opening.
    localparam int TOTAL_ITEMS = 1950;
    // The longest command is a remove that scans the full table and then
    // moves the last entry. Sender gaps add to that, so this leaves a wide
    // margin.
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 150;

    // Opcodes the block does not define; it must treat them as no-ops.
    localparam t_opcode OP_SPARE6 = 3'd6;
    localparam t_opcode OP_SPARE7 = 3'd7;

    logic    i_clk          = 1'b0;
    logic    i_rst_n        = 1'b0;
    logic    start          = 1'b0;
    logic    busy;
    t_opcode i_opcode       = OP_CLEAR;
    t_key    i_stream_id    = '0;
    t_handle i_local_handle = '0;
    logic       o_valid;
    t_status    o_status;
    t_handle    o_found_handle;
    t_key       o_found_stream_id;
    t_count_out o_entry_count;

    map_scoreboard #(MAP_DEPTH) sb;
    int unsigned items_sent = 0;
    int unsigned stall_cycles = 0;

    stream_id_handle_map #(
        .DEPTH(MAP_DEPTH)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_stream_id      (i_stream_id),
        .i_local_handle   (i_local_handle),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_found_handle   (o_found_handle),
        .o_found_stream_id(o_found_stream_id),
        .o_entry_count    (o_entry_count)
    );

    always #1 i_clk = ~i_clk;

    // Monitor and watchdog. All values are sampled as they stood just before
    // the rising edge, since the driver and the block update theirs with
    // nonblocking assignments. A result is checked before a command accepted
    // at the same edge is noted, because that command's answer can only come
    // later.
    always @(posedge i_clk) begin
        logic moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_valid !== 1'b0) begin
                sb.check_answer(o_status, o_found_handle, o_found_stream_id, o_entry_count);
                moved = 1'b1;
            end
            if (start && !busy) begin
                sb.apply_command(i_opcode, i_stream_id, i_local_handle);
                moved = 1'b1;
            end
            if (moved) begin
                stall_cycles <= 0;
            end else if (stall_cycles + 1 >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Presents one command and returns at the edge where it is transferred.
    // Outside the calm stretch the sender idles in about one cycle of ten
    // before each command. The gaps land at random points of the previous
    // command's scan, so the next start arrives at every phase of busy.
    task automatic send_item(input t_opcode op, input t_key sid, input t_handle hnd);
        bit calm;
        calm = (items_sent >= 700) && (items_sent < 1100);
        if (!calm) begin
            while ($urandom_range(99) < 10) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start          <= 1'b1;
        i_opcode       <= op;
        i_stream_id    <= sid;
        i_local_handle <= hnd;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
    endtask

    // Keys come fully random (every bit toggles), from a tiny pool that
    // produces duplicates, or from a live table slot so finds and removes hit.
    function automatic t_key pick_key();
        case ($urandom_range(3))
            0: return $urandom();
            1: return t_key'($urandom_range(7));
            default: begin
                if (sb.fill != 0) return sb.key_tab[$urandom_range(sb.fill - 1)];
                return $urandom();
            end
        endcase
    endfunction

    function automatic t_handle pick_handle();
        case ($urandom_range(3))
            0: return t_handle'($urandom_range(16'hFFFF));
            1: return t_handle'($urandom_range(7));
            default: begin
                if (sb.fill != 0) return sb.hnd_tab[$urandom_range(sb.fill - 1)];
                return t_handle'($urandom_range(16'hFFFF));
            end
        endcase
    endfunction

    // One episode of random commands. add_pct sets the mix: a high share of
    // adds drives the table into overflow, a low one drains it through
    // removes. Clears and the undefined opcodes are the rare noise.
    task automatic random_episode(input int n_items, input int add_pct,
                                  input bit allow_clear);
        int      r;
        t_opcode op;
        for (int n = 0; n < n_items; n++) begin
            r = $urandom_range(99);
            if (r < add_pct) begin
                op = OP_ADD;
            end else if (allow_clear && r >= 98) begin
                case ($urandom_range(2))
                    0: op = OP_CLEAR;
                    1: op = OP_SPARE6;
                    default: op = OP_SPARE7;
                endcase
            end else begin
                case ($urandom_range(3))
                    0: op = OP_FIND_SID;
                    1: op = OP_FIND_HND;
                    2: op = OP_REMOVE_SID;
                    default: op = OP_REMOVE_HND;
                endcase
            end
            send_item(op, pick_key(), pick_handle());
        end
    endtask

    initial begin
        int add_pct;
        int n_ep;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening. Everything on an empty table must miss, then a
        // few pairs with extreme and duplicate values exercise first-match
        // order, hits on zero values and both kinds of removal.
        send_item(OP_CLEAR,      32'h0000_0000, 16'h0000);
        send_item(OP_FIND_SID,   32'h0000_0000, 16'h0000);
        send_item(OP_FIND_HND,   32'h0000_0000, 16'h0000);
        send_item(OP_REMOVE_SID, 32'h0000_0005, 16'h0005);
        send_item(OP_REMOVE_HND, 32'h0000_0005, 16'h0005);
        send_item(OP_ADD,        32'h0000_0000, 16'h0000);
        send_item(OP_ADD,        32'hFFFF_FFFF, 16'hFFFF);
        // Duplicate stream id, then a duplicate handle.
        send_item(OP_ADD,        32'hFFFF_FFFF, 16'h1234);
        send_item(OP_ADD,        32'h0000_0007, 16'hFFFF);
        // Hits whose found value is zero must still report success.
        send_item(OP_FIND_SID,   32'h0000_0000, 16'hABCD);
        send_item(OP_FIND_HND,   32'h1357_9BDF, 16'h0000);
        // Duplicates resolve to the earliest slot.
        send_item(OP_FIND_SID,   32'hFFFF_FFFF, 16'h0000);
        send_item(OP_FIND_HND,   32'h0000_0000, 16'hFFFF);
        send_item(OP_FIND_SID,   32'h1234_5678, 16'h0000);
        send_item(OP_FIND_HND,   32'h0000_0000, 16'h5555);
        send_item(OP_SPARE6,     32'hDEAD_BEEF, 16'hFFFF);
        send_item(OP_SPARE7,     32'hFFFF_FFFF, 16'h0000);
        // Removing slot 0 pulls the last pair (7, FFFF) down into it.
        send_item(OP_REMOVE_SID, 32'h0000_0000, 16'h0000);
        send_item(OP_FIND_HND,   32'h0000_0000, 16'hFFFF);
        // The handle 1234 now sits in the last slot, which just goes away.
        send_item(OP_REMOVE_HND, 32'h0000_0000, 16'h1234);
        send_item(OP_REMOVE_SID, 32'hAAAA_AAAA, 16'h0000);
        send_item(OP_REMOVE_HND, 32'h0000_0000, 16'hFFFF);
        send_item(OP_CLEAR,      32'h5555_5555, 16'hAAAA);
        send_item(OP_FIND_SID,   32'hFFFF_FFFF, 16'h0000);

        // The first episode fills the table well past full, so adds are
        // refused and scans run over all slots; later ones vary the mix.
        // The last episode is cut short so the total stays on target.
        items_sent = 0;
        random_episode(300, 90, 1'b0);
        while (items_sent < TOTAL_ITEMS) begin
            case ($urandom_range(3))
                0: add_pct = 20;
                1: add_pct = 45;
                2: add_pct = 60;
                default: add_pct = 85;
            endcase
            n_ep = int'($urandom_range(120, 320));
            if (n_ep > TOTAL_ITEMS - int'(items_sent)) begin
                n_ep = TOTAL_ITEMS - int'(items_sent);
            end
            random_episode(n_ep, add_pct, 1'b1);
        end
        start <= 1'b0;

        // Let every outstanding answer arrive, then watch a while longer for
        // stray strobes. The watchdog bounds the first wait.
        while (sb.answer_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.answer_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
